@@ design/stl_pkg.sv @@
// Shared types and constants for the sorted task list.
package stl_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_BITS  = 32;
    localparam int SLOT_BITS = 4;
    localparam int CNT_BITS  = 5;
    localparam int OP_BITS   = 3;

    localparam logic [OP_BITS-1:0] OP_INS_SORT = 3'd0;
    localparam logic [OP_BITS-1:0] OP_INS_CUR  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_ROTATE   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_PEEK     = 3'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_LISTED     = 2'd2;
    localparam logic [1:0] ST_NOT_LISTED = 2'd3;

    typedef struct packed {
        logic [OP_BITS-1:0]   opcode;
        logic [SLOT_BITS-1:0] slot_id;
        logic [KEY_BITS-1:0]  sort_key;
    } req_word_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot_out;
        logic [KEY_BITS-1:0]  key_out;
        logic [CNT_BITS-1:0]  entry_count;
        logic [1:0]           status;
    } rsp_word_t;

    typedef struct packed {
        logic                 valid;
        logic                 cur;
        logic [SLOT_BITS-1:0] slot;
        logic [KEY_BITS-1:0]  key;
    } cell_t;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_INS_SORT,
        CM_INS_CUR,
        CM_REMOVE,
        CM_ROTATE
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t           mode;
        logic [SLOT_BITS-1:0] slot;
        logic [KEY_BITS-1:0]  key;
        logic                 wrap;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_REPORT
    } state_t;

endpackage

@@ design/sorted_task_list_with_round_robin.sv @@
// Sorted task list with round-robin cursor: top level.
// The list lives in a row of DEPTH cells, head in cell 0, each cell holding one slot id,
// its key and a cursor flag; inserts and removes shift the cells behind the affected
// position by one place, all in one update. Each word passes from acceptance to the
// result word through the steps accept, update the cell row, form the result; the next
// word is taken in the cycle after the result word has been taken, and no new word is
// taken while a result word waits, so a stall on the result side holds the flow.
module sorted_task_list_with_round_robin import stl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    state_t               state_reg;
    state_t               state_next;
    req_word_t            req_reg;
    logic [DEPTH-1:0]     listed_reg;
    logic [CNT_BITS-1:0]  count_reg;
    logic [1:0]           status_reg;
    logic [KEY_BITS-1:0]  rkey_reg;
    logic                 rsp_valid_reg;
    rsp_word_t            rsp_reg;

    cell_cmd_t            cell_cmd;
    cell_t                cells [DEPTH];
    cell_t                left_in [DEPTH];
    cell_t                right_in [DEPTH];
    logic [DEPTH:0]       found;
    logic [DEPTH:0]       back;
    logic [DEPTH-1:0]     valids;
    logic [DEPTH-1:0]     curs;
    logic                 tail_cur;
    logic [KEY_BITS-1:0]  rm_key;
    logic                 sel_hit;
    cell_t                cur_cell;
    logic                 accept;
    logic                 is_listed;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE) || rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign is_listed = listed_reg[req_reg.slot_id];
    assign found[0]  = 1'b0;
    assign back[DEPTH] = 1'b0;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valids[i] = cells[i].valid;
            curs[i]   = cells[i].cur;
            if (i == 0)
            begin
                left_in[i] = '{valid: 1'b1, cur: 1'b0, slot: '0, key: '0};
            end
            else
            begin
                left_in[i] = cells[i-1];
            end
            if (i == DEPTH - 1)
            begin
                right_in[i] = '{valid: 1'b0, cur: 1'b0, slot: '0, key: '0};
            end
            else
            begin
                right_in[i] = cells[i+1];
            end
        end
    end

    always_comb
    begin
        tail_cur = 1'b0;
        rm_key   = '0;
        sel_hit  = 1'b0;
        cur_cell = '{valid: 1'b0, cur: 1'b0, slot: '0, key: '0};
        for (int i = 0; i < DEPTH; i++)
        begin
            if (curs[i] && (i == DEPTH - 1 || !right_in[i].valid))
            begin
                tail_cur = 1'b1;
            end
            sel_hit = valids[i] && (cells[i].slot == req_reg.slot_id);
            if (sel_hit)
            begin
                rm_key = rm_key | cells[i].key;
            end
            if (curs[i])
            begin
                cur_cell = cur_cell | cells[i];
            end
        end
    end

    always_comb
    begin
        cell_cmd.mode = CM_HOLD;
        cell_cmd.slot = req_reg.slot_id;
        cell_cmd.key  = req_reg.sort_key;
        cell_cmd.wrap = !(|curs) || tail_cur;
        if (state_reg == S_APPLY)
        begin
            priority if (req_reg.opcode == OP_INS_SORT && !is_listed)
            begin
                cell_cmd.mode = CM_INS_SORT;
            end
            else if (req_reg.opcode == OP_INS_CUR && !is_listed)
            begin
                cell_cmd.mode = CM_INS_CUR;
            end
            else if (req_reg.opcode == OP_REMOVE && is_listed)
            begin
                cell_cmd.mode = CM_REMOVE;
            end
            else if (req_reg.opcode == OP_ROTATE && count_reg != '0)
            begin
                cell_cmd.mode = CM_ROTATE;
            end
            else
            begin
                cell_cmd.mode = CM_HOLD;
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        stl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .head      (g == 0),
            .cmd       (cell_cmd),
            .left      (left_in[g]),
            .right     (right_in[g]),
            .found_in  (found[g]),
            .found_out (found[g+1]),
            .back_in   (back[g+1]),
            .back_out  (back[g]),
            .data      (cells[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   state_next = accept ? S_APPLY : S_IDLE;
            S_APPLY:  state_next = S_REPORT;
            S_REPORT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listed_reg    <= '0;
            count_reg     <= '0;
            status_reg    <= ST_OK;
            rkey_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (state_reg == S_APPLY)
            begin
                if (req_reg.opcode == OP_INS_SORT || req_reg.opcode == OP_INS_CUR)
                begin
                    rkey_reg <= req_reg.sort_key;
                    if (is_listed)
                    begin
                        status_reg <= ST_LISTED;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        listed_reg[req_reg.slot_id] <= 1'b1;
                        count_reg <= count_reg + CNT_BITS'(1);
                    end
                end
                else if (req_reg.opcode == OP_REMOVE)
                begin
                    if (!is_listed)
                    begin
                        status_reg <= ST_NOT_LISTED;
                        rkey_reg   <= '0;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        rkey_reg   <= rm_key;
                        listed_reg[req_reg.slot_id] <= 1'b0;
                        count_reg <= count_reg - CNT_BITS'(1);
                    end
                end
                else
                begin
                    status_reg <= ST_OK;
                    rkey_reg   <= '0;
                end
            end
            if (state_reg == S_REPORT)
            begin
                rsp_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_REPORT)
        begin
            rsp_reg.entry_count <= count_reg;
            if ((req_reg.opcode == OP_ROTATE || req_reg.opcode == OP_PEEK) && count_reg == '0)
            begin
                rsp_reg.slot_out <= '0;
                rsp_reg.key_out  <= '1;
                rsp_reg.status   <= ST_EMPTY;
            end
            else if (req_reg.opcode == OP_ROTATE)
            begin
                rsp_reg.slot_out <= cur_cell.slot;
                rsp_reg.key_out  <= cur_cell.key;
                rsp_reg.status   <= status_reg;
            end
            else if (req_reg.opcode == OP_PEEK)
            begin
                rsp_reg.slot_out <= cells[0].slot;
                rsp_reg.key_out  <= cells[0].key;
                rsp_reg.status   <= status_reg;
            end
            else
            begin
                rsp_reg.slot_out <= req_reg.slot_id;
                rsp_reg.key_out  <= rkey_reg;
                rsp_reg.status   <= status_reg;
            end
        end
    end

    a_one_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(curs))
        else $error("more than one cell holds the cursor");

    a_count_cells: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_BITS'($countones(valids)))
        else $error("entry count differs from occupied cells");

    a_count_listed: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_BITS'($countones(listed_reg)))
        else $error("entry count differs from listed slots");

    a_packed_row: assert property (@(posedge clk) disable iff (!rst_n)
        (valids & ~(valids >> 1) & (valids >> 1)) == '0 && ((valids + 1'b1) & valids) == '0)
        else $error("occupied cells are not packed at the head");

endmodule

@@ design/stl_cell.sv @@
// One list position: holds an entry and shifts with its neighbors.
module stl_cell import stl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head,
    input  cell_cmd_t cmd,
    input  cell_t     left,
    input  cell_t     right,
    input  logic      found_in,
    output logic      found_out,
    input  logic      back_in,
    output logic      back_out,
    output cell_t     data
);

    cell_t cell_reg;
    cell_t cell_next;
    logic  hit;

    always_comb
    begin
        unique case (cmd.mode)
            CM_INS_SORT: hit = cell_reg.valid && (cell_reg.key > cmd.key);
            CM_INS_CUR:  hit = cell_reg.valid && cell_reg.cur;
            CM_REMOVE:   hit = cell_reg.valid && (cell_reg.slot == cmd.slot);
            default:     hit = 1'b0;
        endcase
    end

    assign found_out = found_in | hit;
    assign back_out  = (cmd.mode == CM_REMOVE) && hit && cell_reg.cur;
    assign data      = cell_reg;

    always_comb
    begin
        cell_next = cell_reg;
        unique case (cmd.mode)
            CM_INS_SORT, CM_INS_CUR:
            begin
                if (found_in)
                begin
                    cell_next = left;
                end
                else if (hit || (!cell_reg.valid && left.valid))
                begin
                    cell_next = '{valid: 1'b1, cur: 1'b0, slot: cmd.slot, key: cmd.key};
                end
            end
            CM_REMOVE:
            begin
                if (found_out)
                begin
                    cell_next = right;
                end
                else if (back_in)
                begin
                    cell_next.cur = 1'b1;
                end
            end
            CM_ROTATE:
            begin
                cell_next.cur = (left.cur && cell_reg.valid) || (head && cmd.wrap);
            end
            default:
            begin
                cell_next = cell_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

endmodule
